### sv/ps2sc_pkg.sv
package ps2sc_pkg;

   // Set-1 scancodes with a fixed meaning
   localparam logic [7:0] KeyReleaseBit = 8'h80;
   localparam logic [7:0] KeyLshiftUp   = 8'hAA;
   localparam logic [7:0] KeyRshiftUp   = 8'hB6;
   localparam logic [7:0] KeyCtrlUp     = 8'h9D;
   localparam logic [7:0] KeyBackspace  = 8'h0E;
   localparam logic [7:0] KeyTab        = 8'h0F;
   localparam logic [7:0] KeyEnter      = 8'h1C;
   localparam logic [7:0] KeyCtrl       = 8'h1D;
   localparam logic [7:0] KeyLshift     = 8'h2A;
   localparam logic [7:0] KeyRshift     = 8'h36;
   localparam logic [7:0] KeySpace      = 8'h39;
   localparam logic [7:0] KeyCaps       = 8'h3A;
   localparam logic [7:0] KeyLeft       = 8'h4B;
   localparam logic [7:0] KeyRight      = 8'h4D;

   // ASCII codes given for the fixed keys
   localparam logic [6:0] AsciiBackspace = 7'h08;
   localparam logic [6:0] AsciiTab       = 7'h09;
   localparam logic [6:0] AsciiNewline   = 7'h0A;
   localparam logic [6:0] AsciiSpace     = 7'h20;

   // Configuration register indexes
   localparam logic CsrEnable = 1'b0;
   localparam logic CsrEcho   = 1'b1;

   localparam int RspWidth = 16;

   typedef struct packed {
      logic shift;
      logic ctrl;
      logic caps;
   } flags_type;

   // Result fields, char_code in the lowest bits
   typedef struct packed {
      logic       caps_now;
      logic       ctrl_now;
      logic       shift_now;
      logic       cursor_right;
      logic       cursor_left;
      logic       echo;
      logic       char_valid;
      logic [6:0] char_code;
   } result_type;

   // US layout for make codes 0x02..0x35; everything else has no character
   function automatic logic [6:0] layout(input logic [6:0] code);
      logic [6:0] ch;
      unique case (code)
         7'd2:    ch = 7'h31;
         7'd3:    ch = 7'h32;
         7'd4:    ch = 7'h33;
         7'd5:    ch = 7'h34;
         7'd6:    ch = 7'h35;
         7'd7:    ch = 7'h36;
         7'd8:    ch = 7'h37;
         7'd9:    ch = 7'h38;
         7'd10:   ch = 7'h39;
         7'd11:   ch = 7'h30;
         7'd12:   ch = 7'h2D;
         7'd13:   ch = 7'h3D;
         7'd14:   ch = 7'h08;
         7'd15:   ch = 7'h09;
         7'd16:   ch = 7'h71;
         7'd17:   ch = 7'h77;
         7'd18:   ch = 7'h65;
         7'd19:   ch = 7'h72;
         7'd20:   ch = 7'h74;
         7'd21:   ch = 7'h79;
         7'd22:   ch = 7'h75;
         7'd23:   ch = 7'h69;
         7'd24:   ch = 7'h6F;
         7'd25:   ch = 7'h70;
         7'd26:   ch = 7'h5B;
         7'd27:   ch = 7'h5D;
         7'd28:   ch = 7'h0A;
         7'd30:   ch = 7'h61;
         7'd31:   ch = 7'h73;
         7'd32:   ch = 7'h64;
         7'd33:   ch = 7'h66;
         7'd34:   ch = 7'h67;
         7'd35:   ch = 7'h68;
         7'd36:   ch = 7'h6A;
         7'd37:   ch = 7'h6B;
         7'd38:   ch = 7'h6C;
         7'd39:   ch = 7'h3B;
         7'd40:   ch = 7'h27;
         7'd41:   ch = 7'h60;
         7'd43:   ch = 7'h5C;
         7'd44:   ch = 7'h7A;
         7'd45:   ch = 7'h78;
         7'd46:   ch = 7'h63;
         7'd47:   ch = 7'h76;
         7'd48:   ch = 7'h62;
         7'd49:   ch = 7'h6E;
         7'd50:   ch = 7'h6D;
         7'd51:   ch = 7'h2C;
         7'd52:   ch = 7'h2E;
         7'd53:   ch = 7'h2F;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Symbol on the same key with shift held; other characters pass through
   function automatic logic [6:0] shifted_symbol(input logic [6:0] ch);
      logic [6:0] res;
      unique case (ch)
         7'h60:   res = 7'h7E;
         7'h31:   res = 7'h21;
         7'h32:   res = 7'h40;
         7'h33:   res = 7'h23;
         7'h34:   res = 7'h24;
         7'h35:   res = 7'h25;
         7'h36:   res = 7'h5E;
         7'h37:   res = 7'h26;
         7'h38:   res = 7'h2A;
         7'h39:   res = 7'h28;
         7'h30:   res = 7'h29;
         7'h2D:   res = 7'h5F;
         7'h3D:   res = 7'h2B;
         7'h5B:   res = 7'h7B;
         7'h5D:   res = 7'h7D;
         7'h5C:   res = 7'h7C;
         7'h3B:   res = 7'h3A;
         7'h27:   res = 7'h22;
         7'h2C:   res = 7'h3C;
         7'h2E:   res = 7'h3E;
         7'h2F:   res = 7'h3F;
         default: res = ch;
      endcase
      return res;
   endfunction

   function automatic logic is_lower(input logic [6:0] ch);
      return (ch >= 7'h61) && (ch <= 7'h7A);
   endfunction

   function automatic logic [6:0] upper(input logic [6:0] ch);
      return is_lower(ch) ? (ch - 7'd32) : ch;
   endfunction

endpackage

### sv/ps2_scancode_to_ascii.sv
// PS/2 set-1 scancode decoder. Each request carries one raw scancode byte and
// gives exactly one response: the ASCII character (char_valid marks it, echo
// adds the echo_enable setting), left/right arrow events and the shift, ctrl
// and caps-lock flags as they stand after that scancode. A request is captured
// in an input register and decoded by a table lookup and case mapping into the
// response register, so one scancode is taken every cycle while responses are
// taken; the only feedback is the three-bit flag register, which is updated
// in the same cycle a scancode moves into the response register. The response
// register decouples the sides, so a request is still accepted while a response
// waits if the input register is empty. The user must make CSR writes (index
// 0 enable, index 1 echo_enable) while no request is in flight; not enforced.
module ps2_scancode_to_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scancode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [6:0] char_code, [7] char_valid, [8] echo,
                                    // [9] cursor_left, [10] cursor_right,
                                    // [11] shift_now, [12] ctrl_now, [13] caps_now,
                                    // [15:14] zero
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata
);

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_code_ff, in_code_in;
   logic                  out_valid_ff, out_valid_in;
   ps2sc_pkg::result_type out_data_ff, out_data_in;
   ps2sc_pkg::flags_type  flags_ff, flags_in;
   logic                  enable_ff, enable_in;
   logic                  echo_en_ff, echo_en_in;

   ps2sc_pkg::flags_type  flags_next;
   ps2sc_pkg::result_type result;
   logic                  out_free;
   logic                  advance;
   logic                  req_take;

   // Handshake: the decode stage moves whenever the response register frees up
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   ps2sc_decode u_decode (
      .enable      (enable_ff),
      .echo_enable (echo_en_ff),
      .scancode    (in_code_ff),
      .flags       (flags_ff),
      .flags_next  (flags_next),
      .result      (result)
   );

   // Next-state logic
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !out_free);
      in_code_in   = req_take ? req_tdata : in_code_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      out_data_in  = advance ? result : out_data_ff;
      flags_in     = advance ? flags_next : flags_ff;
      enable_in    = enable_ff;
      echo_en_in   = echo_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            ps2sc_pkg::CsrEnable: enable_in  = csr_wdata;
            ps2sc_pkg::CsrEcho:   echo_en_in = csr_wdata;
            default:              enable_in  = enable_ff;
         endcase
      end
   end

   // Control and flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
         enable_ff    <= 1'b1;
         echo_en_ff   <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
         enable_ff    <= enable_in;
         echo_en_ff   <= echo_en_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_code_ff  <= in_code_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(ps2sc_pkg::RspWidth - $bits(ps2sc_pkg::result_type))'(0), out_data_ff};

`ifndef ASSERT_OFF
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(flags_ff))
      else $error("flags changed without a decoded scancode");

   a_valid_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff.char_valid == (out_data_ff.char_code != 7'h00)))
      else $error("char_valid disagrees with char_code");

   a_echo_char: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.echo |-> out_data_ff.char_valid)
      else $error("echo without a character");

   a_event_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot0({out_data_ff.cursor_left, out_data_ff.cursor_right,
                                 out_data_ff.char_valid}))
      else $error("cursor event and character in one response");

   a_flags_shown: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_data_ff.shift_now == flags_ff.shift) &&
                  (out_data_ff.ctrl_now == flags_ff.ctrl) &&
                  (out_data_ff.caps_now == flags_ff.caps))
      else $error("response flags differ from flag register");
`endif

endmodule

### sv/ps2sc_decode.sv
module ps2sc_decode (
   input  logic                  enable,
   input  logic                  echo_enable,
   input  logic [7:0]            scancode,
   input  ps2sc_pkg::flags_type  flags,
   output ps2sc_pkg::flags_type  flags_next,
   output ps2sc_pkg::result_type result
);

   logic [6:0] ch;
   logic [6:0] base;
   logic       left;
   logic       right;

   assign base = ps2sc_pkg::layout(scancode[6:0]);

   // Decode one scancode against the current flags
   always_comb begin
      flags_next = flags;
      ch         = 7'h00;
      left       = 1'b0;
      right      = 1'b0;
      if (enable) begin
         if ((scancode & ps2sc_pkg::KeyReleaseBit) != 8'h00) begin
            if (scancode == ps2sc_pkg::KeyLshiftUp || scancode == ps2sc_pkg::KeyRshiftUp) begin
               flags_next.shift = 1'b0;
            end
            if (scancode == ps2sc_pkg::KeyCtrlUp) begin
               flags_next.ctrl = 1'b0;
            end
         end else begin
            unique case (scancode)
               ps2sc_pkg::KeyCaps:      flags_next.caps = ~flags.caps;
               ps2sc_pkg::KeyEnter:     ch = ps2sc_pkg::AsciiNewline;
               ps2sc_pkg::KeyLshift,
               ps2sc_pkg::KeyRshift:    flags_next.shift = 1'b1;
               ps2sc_pkg::KeyCtrl:      flags_next.ctrl = 1'b1;
               ps2sc_pkg::KeyTab:       ch = ps2sc_pkg::AsciiTab;
               ps2sc_pkg::KeyLeft:      left = 1'b1;
               ps2sc_pkg::KeyRight:     right = 1'b1;
               ps2sc_pkg::KeySpace:     ch = ps2sc_pkg::AsciiSpace;
               ps2sc_pkg::KeyBackspace: ch = ps2sc_pkg::AsciiBackspace;
               default: begin
                  // caps with shift gives symbols only, letters stay lower
                  if (flags.caps) begin
                     ch = flags.shift ? ps2sc_pkg::shifted_symbol(base)
                                      : ps2sc_pkg::upper(base);
                  end else if (flags.shift) begin
                     ch = ps2sc_pkg::is_lower(base) ? ps2sc_pkg::upper(base)
                                                    : ps2sc_pkg::shifted_symbol(base);
                  end else begin
                     ch = base;
                  end
               end
            endcase
         end
      end
   end

   // Pack the result
   always_comb begin
      result.char_code    = ch;
      result.char_valid   = (ch != 7'h00);
      result.echo         = (ch != 7'h00) && echo_enable;
      result.cursor_left  = left;
      result.cursor_right = right;
      result.shift_now    = flags_next.shift;
      result.ctrl_now     = flags_next.ctrl;
      result.caps_now     = flags_next.caps;
   end

endmodule

### test/tb_ps2_scancode_to_ascii.sv
`timescale 1ns / 1ps

module tb_ps2_scancode_to_ascii;

   localparam int         CycleLimit   = 300000;
   localparam logic [7:0] KeyExtPrefix = 8'hE0;

   typedef struct {
      logic [7:0]            code;
      ps2sc_pkg::result_type res;
   } decode_entry_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] scancode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [6:0] char_code, [7] char_valid, [8] echo,
                                      // [9] cursor_left, [10] cursor_right,
                                      // [11] shift_now, [12] ctrl_now, [13] caps_now
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic        csr_wdata  = 1'b0;

   // Scancodes waiting to be sent, decodes waiting for their response
   logic [7:0]            scancode_q[$];
   decode_entry_type      decodes_due[$];
   decode_entry_type      accepted;
   decode_entry_type      due;
   ps2sc_pkg::result_type got;

   // Decoder state as the testbench tracks it
   logic cfg_enable = 1'b1;
   logic cfg_echo   = 1'b1;
   logic held_shift = 1'b0;
   logic held_ctrl  = 1'b0;
   logic caps_lock  = 1'b0;

   bit idle_on    = 1'b1;
   int send_gap   = 0;
   int stall_left = 0;
   int fail_count = 0;
   int cycle_count = 0;

   ps2_scancode_to_ascii dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // US keyboard row layout for make codes 2 to 53
   function automatic logic [6:0] us_key(input logic [7:0] code);
      logic [6:0] ch;
      case (code)
         8'd2:  ch = 7'h31;  8'd3:  ch = 7'h32;  8'd4:  ch = 7'h33;  8'd5:  ch = 7'h34;
         8'd6:  ch = 7'h35;  8'd7:  ch = 7'h36;  8'd8:  ch = 7'h37;  8'd9:  ch = 7'h38;
         8'd10: ch = 7'h39;  8'd11: ch = 7'h30;  8'd12: ch = 7'h2D;  8'd13: ch = 7'h3D;
         8'd14: ch = 7'h08;  8'd15: ch = 7'h09;
         8'd16: ch = 7'h71;  8'd17: ch = 7'h77;  8'd18: ch = 7'h65;  8'd19: ch = 7'h72;
         8'd20: ch = 7'h74;  8'd21: ch = 7'h79;  8'd22: ch = 7'h75;  8'd23: ch = 7'h69;
         8'd24: ch = 7'h6F;  8'd25: ch = 7'h70;  8'd26: ch = 7'h5B;  8'd27: ch = 7'h5D;
         8'd28: ch = 7'h0A;
         8'd30: ch = 7'h61;  8'd31: ch = 7'h73;  8'd32: ch = 7'h64;  8'd33: ch = 7'h66;
         8'd34: ch = 7'h67;  8'd35: ch = 7'h68;  8'd36: ch = 7'h6A;  8'd37: ch = 7'h6B;
         8'd38: ch = 7'h6C;  8'd39: ch = 7'h3B;  8'd40: ch = 7'h27;  8'd41: ch = 7'h60;
         8'd43: ch = 7'h5C;
         8'd44: ch = 7'h7A;  8'd45: ch = 7'h78;  8'd46: ch = 7'h63;  8'd47: ch = 7'h76;
         8'd48: ch = 7'h62;  8'd49: ch = 7'h6E;  8'd50: ch = 7'h6D;  8'd51: ch = 7'h2C;
         8'd52: ch = 7'h2E;  8'd53: ch = 7'h2F;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   // Symbol printed on the same key with shift held
   function automatic logic [6:0] shift_sym(input logic [6:0] ch);
      logic [6:0] res;
      case (ch)
         7'h60: res = 7'h7E;  7'h31: res = 7'h21;  7'h32: res = 7'h40;  7'h33: res = 7'h23;
         7'h34: res = 7'h24;  7'h35: res = 7'h25;  7'h36: res = 7'h5E;  7'h37: res = 7'h26;
         7'h38: res = 7'h2A;  7'h39: res = 7'h28;  7'h30: res = 7'h29;  7'h2D: res = 7'h5F;
         7'h3D: res = 7'h2B;  7'h5B: res = 7'h7B;  7'h5D: res = 7'h7D;  7'h5C: res = 7'h7C;
         7'h3B: res = 7'h3A;  7'h27: res = 7'h22;  7'h2C: res = 7'h3C;  7'h2E: res = 7'h3E;
         7'h2F: res = 7'h3F;
         default: res = ch;
      endcase
      return res;
   endfunction

   function automatic logic is_letter(input logic [6:0] ch);
      return ch >= 7'h61 && ch <= 7'h7A;
   endfunction

   function automatic logic [6:0] to_upper(input logic [6:0] ch);
      return is_letter(ch) ? ch - 7'h20 : ch;
   endfunction

   // Decode one scancode against the tracked flags and update them
   function automatic ps2sc_pkg::result_type decode_key(input logic [7:0] code);
      ps2sc_pkg::result_type r;
      logic [6:0]            ch;
      r  = '0;
      ch = 7'h00;
      if (cfg_enable) begin
         if (code[7]) begin
            if (code == ps2sc_pkg::KeyLshiftUp || code == ps2sc_pkg::KeyRshiftUp)
               held_shift = 1'b0;
            if (code == ps2sc_pkg::KeyCtrlUp) held_ctrl = 1'b0;
         end else begin
            case (code)
               ps2sc_pkg::KeyCaps:      caps_lock = ~caps_lock;
               ps2sc_pkg::KeyEnter:     ch = ps2sc_pkg::AsciiNewline;
               ps2sc_pkg::KeyLshift,
               ps2sc_pkg::KeyRshift:    held_shift = 1'b1;
               ps2sc_pkg::KeyCtrl:      held_ctrl = 1'b1;
               ps2sc_pkg::KeyTab:       ch = ps2sc_pkg::AsciiTab;
               ps2sc_pkg::KeyLeft:      r.cursor_left = 1'b1;
               ps2sc_pkg::KeyRight:     r.cursor_right = 1'b1;
               ps2sc_pkg::KeySpace:     ch = ps2sc_pkg::AsciiSpace;
               ps2sc_pkg::KeyBackspace: ch = ps2sc_pkg::AsciiBackspace;
               default: begin
                  ch = us_key(code);
                  if (caps_lock) begin
                     ch = held_shift ? shift_sym(ch) : to_upper(ch);
                  end else if (held_shift) begin
                     ch = is_letter(ch) ? to_upper(ch) : shift_sym(ch);
                  end
               end
            endcase
         end
      end
      r.char_code  = ch;
      r.char_valid = ch != 7'h00;
      r.echo       = ch != 7'h00 && cfg_echo;
      r.shift_now  = held_shift;
      r.ctrl_now   = held_ctrl;
      r.caps_now   = caps_lock;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] code,
                              input logic [6:0] exp, input logic [6:0] act);
      if (exp !== act) begin
         $display("%0t: scancode %h %s expected %h actual %h", $time, code, name, exp, act);
         fail_count++;
      end
   endtask

   // Driver: hold a request until accepted, predict it on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted.code = req_tdata;
            accepted.res  = decode_key(req_tdata);
            decodes_due.push_back(accepted);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (scancode_q.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= scancode_q.pop_front();
               if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest decode, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decodes_due.size() == 0) begin
               $display("%0t: response expected none actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               due = decodes_due.pop_front();
               got = rsp_tdata[13:0];
               check_field("char_code", due.code, due.res.char_code, got.char_code);
               check_field("char_valid", due.code, 7'(due.res.char_valid),
                           7'(got.char_valid));
               check_field("echo", due.code, 7'(due.res.echo), 7'(got.echo));
               check_field("cursor_left", due.code, 7'(due.res.cursor_left),
                           7'(got.cursor_left));
               check_field("cursor_right", due.code, 7'(due.res.cursor_right),
                           7'(got.cursor_right));
               check_field("shift_now", due.code, 7'(due.res.shift_now),
                           7'(got.shift_now));
               check_field("ctrl_now", due.code, 7'(due.res.ctrl_now), 7'(got.ctrl_now));
               check_field("caps_now", due.code, 7'(due.res.caps_now), 7'(got.caps_now));
               check_field("pad", due.code, 7'h00, {5'h00, rsp_tdata[15:14]});
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 17);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d decodes outstanding", $time, decodes_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Wait until every request is sent and answered, then let the pipe drain
   task automatic wait_idle();
      do @(negedge clock);
      while (scancode_q.size() != 0 || req_tvalid || decodes_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == ps2sc_pkg::CsrEnable) cfg_enable = val;
      else cfg_echo = val;
   endtask

   task automatic set_config(input logic en, input logic ec);
      wait_idle();
      write_csr(ps2sc_pkg::CsrEnable, en);
      write_csr(ps2sc_pkg::CsrEcho, ec);
      @(negedge clock);
   endtask

   // Mostly keystroke runs with random content, some noise and broken runs
   task automatic queue_keystrokes(input int count);
      int unsigned pick;
      int unsigned n;
      logic [7:0]  code;
      while (scancode_q.size() < count) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1, 2, 3: begin
               // typing, half the time under shift, release sometimes lost
               if (pick < 2)
                  scancode_q.push_back($urandom_range(0, 1) ? ps2sc_pkg::KeyLshift
                                                            : ps2sc_pkg::KeyRshift);
               n = $urandom_range(1, 4);
               repeat (n) begin
                  code = 8'($urandom_range(2, 53));
                  scancode_q.push_back(code);
               end
               if (pick < 2 && $urandom_range(0, 7) != 0)
                  scancode_q.push_back($urandom_range(0, 1) ? ps2sc_pkg::KeyLshiftUp
                                                            : ps2sc_pkg::KeyRshiftUp);
            end
            4: begin
               scancode_q.push_back(ps2sc_pkg::KeyCaps);
               if ($urandom_range(0, 1))
                  scancode_q.push_back(ps2sc_pkg::KeyCaps | ps2sc_pkg::KeyReleaseBit);
            end
            5: begin
               scancode_q.push_back(ps2sc_pkg::KeyCtrl);
               code = 8'($urandom_range(2, 53));
               scancode_q.push_back(code);
               if ($urandom_range(0, 5) != 0) scancode_q.push_back(ps2sc_pkg::KeyCtrlUp);
            end
            6: begin
               case ($urandom_range(0, 5))
                  0: scancode_q.push_back(ps2sc_pkg::KeyEnter);
                  1: scancode_q.push_back(ps2sc_pkg::KeyTab);
                  2: scancode_q.push_back(ps2sc_pkg::KeySpace);
                  3: scancode_q.push_back(ps2sc_pkg::KeyBackspace);
                  default: begin
                     // extended arrow press and release
                     code = $urandom_range(0, 1) ? ps2sc_pkg::KeyLeft : ps2sc_pkg::KeyRight;
                     scancode_q.push_back(KeyExtPrefix);
                     scancode_q.push_back(code);
                     scancode_q.push_back(KeyExtPrefix);
                     scancode_q.push_back(code | ps2sc_pkg::KeyReleaseBit);
                  end
               endcase
            end
            7: begin
               code = 8'($urandom_range(0, 127));
               scancode_q.push_back(code);
               scancode_q.push_back(code | ps2sc_pkg::KeyReleaseBit);
            end
            default: begin
               code = 8'($urandom_range(0, 255));
               scancode_q.push_back(code);
            end
         endcase
      end
   endtask

   initial begin
      logic [7:0] directed [24];

      directed = '{
         8'h00, 8'h1E, 8'h02, ps2sc_pkg::KeyBackspace, ps2sc_pkg::KeyTab,
         ps2sc_pkg::KeyEnter, ps2sc_pkg::KeySpace, ps2sc_pkg::KeyLeft,
         ps2sc_pkg::KeyRight, ps2sc_pkg::KeyLshift, 8'h1E, 8'h02,
         ps2sc_pkg::KeyLshiftUp, ps2sc_pkg::KeyCaps, 8'h1E, ps2sc_pkg::KeyRshift,
         8'h29, ps2sc_pkg::KeyRshiftUp, ps2sc_pkg::KeyCtrl, ps2sc_pkg::KeyCtrlUp,
         KeyExtPrefix, 8'hFF, 8'h7F, ps2sc_pkg::KeyCaps
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass under the reset settings
      foreach (directed[i]) scancode_q.push_back(directed[i]);

      set_config(1'b1, 1'b0);
      queue_keystrokes(200);

      // Disabled: flags must hold and no character or cursor event is produced
      set_config(1'b0, 1'b1);
      queue_keystrokes(40);
      set_config(1'b0, 1'b0);
      queue_keystrokes(20);

      set_config(1'b1, 1'b1);
      queue_keystrokes(250);

      // Full rate on both sides to finish
      wait_idle();
      idle_on = 1'b0;
      queue_keystrokes(150);

      wait_idle();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
sv/ps2sc_pkg.sv
sv/ps2sc_decode.sv
sv/ps2_scancode_to_ascii.sv
test/tb_ps2_scancode_to_ascii.sv
